// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the hsv to rgb color converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // per-pixel control data carried down the pipeline
    typedef struct packed {
        logic       grey;
        logic [2:0] sector;
        logic [7:0] val;
        logic [7:0] floor_lvl;
    } ctx_t;

    localparam int SECTOR_DEG = 60;
    localparam int TURN_DEG   = 360;
    localparam int FULL_SCALE = 255;

    // sector codes, named after the hue range they cover
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    // level divide: numerator >> frac bits, then exact divide by 255*60
    localparam int DIV_BASE  = FULL_SCALE * SECTOR_DEG;
    localparam int LVL_W     = 22;
    localparam int DIV_SHIFT = 36;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(DIV_BASE) - 64'd1) / 64'(DIV_BASE);
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

endpackage

// ===== design/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Hue wrap and sector decode stage: splits hue into sector and position.
// ----------------------------------------------------------------------------
module hsv2rgb_sector #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SECTOR_W      = 60 << HUE_FRAC_BITS,
    parameter int POS_W         = $clog2(SECTOR_W)
) (
    input  logic                    clk,
    input  logic                    en,
    input  hsv2rgb_pkg::hsv_t       pix,
    output hsv2rgb_pkg::ctx_t       ctx,
    output logic [POS_W-1:0]        pos,
    output logic [7:0]              sat
);

    localparam logic [31:0] FULL_TURN = 32'(hsv2rgb_pkg::TURN_DEG) << HUE_FRAC_BITS;
    localparam logic [31:0] W1 = 32'(SECTOR_W);
    localparam logic [31:0] W2 = 32'(2 * SECTOR_W);
    localparam logic [31:0] W3 = 32'(3 * SECTOR_W);
    localparam logic [31:0] W4 = 32'(4 * SECTOR_W);
    localparam logic [31:0] W5 = 32'(5 * SECTOR_W);

    logic [31:0]       hue_ext;
    logic [31:0]       hue_wrap;
    logic [31:0]       base;
    logic [2:0]        sector;
    hsv2rgb_pkg::ctx_t ctx_next;
    hsv2rgb_pkg::ctx_t ctx_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  pos_reg;
    logic [7:0]        sat_reg;

    assign hue_ext  = {16'd0, pix.hue};
    assign hue_wrap = (hue_ext >= FULL_TURN) ? 32'd0 : hue_ext;

    always_comb
    begin
        if (hue_wrap >= W5)
        begin
            sector = hsv2rgb_pkg::SEC_MAG_RED;
            base   = W5;
        end
        else if (hue_wrap >= W4)
        begin
            sector = hsv2rgb_pkg::SEC_BLU_MAG;
            base   = W4;
        end
        else if (hue_wrap >= W3)
        begin
            sector = hsv2rgb_pkg::SEC_CYN_BLU;
            base   = W3;
        end
        else if (hue_wrap >= W2)
        begin
            sector = hsv2rgb_pkg::SEC_GRN_CYN;
            base   = W2;
        end
        else if (hue_wrap >= W1)
        begin
            sector = hsv2rgb_pkg::SEC_YEL_GRN;
            base   = W1;
        end
        else
        begin
            sector = hsv2rgb_pkg::SEC_RED_YEL;
            base   = 32'd0;
        end
    end

    always_comb
    begin
        pos_next           = POS_W'(hue_wrap - base);
        ctx_next.grey      = (pix.saturation == 8'd0);
        ctx_next.sector    = sector;
        ctx_next.val       = pix.brightness;
        ctx_next.floor_lvl = 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx_next;
            pos_reg <= pos_next;
            sat_reg <= pix.saturation;
        end
    end

    assign ctx = ctx_reg;
    assign pos = pos_reg;
    assign sat = sat_reg;

endmodule

// ===== design/hsv2rgb_levels.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_levels
// Two stages: saturation products, then value-scaled level numerators and
// the floor level.
// ----------------------------------------------------------------------------
module hsv2rgb_levels #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SECTOR_W      = 60 << HUE_FRAC_BITS,
    parameter int POS_W         = $clog2(SECTOR_W)
) (
    input  logic                                clk,
    input  logic [1:0]                          en,
    input  hsv2rgb_pkg::ctx_t                   ctx_in,
    input  logic [POS_W-1:0]                    pos,
    input  logic [7:0]                          sat,
    output hsv2rgb_pkg::ctx_t                   ctx_out,
    output logic [hsv2rgb_pkg::LVL_W-1:0]       fall_num,
    output logic [hsv2rgb_pkg::LVL_W-1:0]       rise_num
);

    localparam int DEN    = hsv2rgb_pkg::DIV_BASE << HUE_FRAC_BITS;
    localparam int DEN_W  = $clog2(DEN + 1);
    localparam int PROD_W = 8 + POS_W;
    localparam int NUM_W  = 8 + DEN_W;
    localparam int LVL_W  = hsv2rgb_pkg::LVL_W;

    // first stage
    logic [PROD_W-1:0] sp_next, sp_reg;
    logic [PROD_W-1:0] sq_next, sq_reg;
    logic [15:0]       fl_next, fl_reg;
    hsv2rgb_pkg::ctx_t ctx1_reg;

    // second stage
    logic [DEN_W-1:0]  fall_diff;
    logic [DEN_W-1:0]  rise_diff;
    logic [NUM_W-1:0]  fall_m;
    logic [NUM_W-1:0]  rise_m;
    logic [16:0]       fl_sum;
    logic [LVL_W-1:0]  fall_next, fall_reg;
    logic [LVL_W-1:0]  rise_next, rise_reg;
    hsv2rgb_pkg::ctx_t ctx2_next, ctx2_reg;

    always_comb
    begin
        sp_next = PROD_W'(sat) * PROD_W'(pos);
        sq_next = PROD_W'(sat) * PROD_W'(POS_W'(SECTOR_W) - pos);
        fl_next = 16'(ctx_in.val) * 16'(8'(hsv2rgb_pkg::FULL_SCALE) - sat);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sp_reg   <= sp_next;
            sq_reg   <= sq_next;
            fl_reg   <= fl_next;
            ctx1_reg <= ctx_in;
        end
    end

    always_comb
    begin
        fall_diff = DEN_W'(DEN) - DEN_W'(sp_reg);
        rise_diff = DEN_W'(DEN) - DEN_W'(sq_reg);
        fall_m    = NUM_W'(ctx1_reg.val) * NUM_W'(fall_diff);
        rise_m    = NUM_W'(ctx1_reg.val) * NUM_W'(rise_diff);
        // drop the hue fraction bits first, the rest divides by 255*60
        fall_next = LVL_W'(fall_m >> HUE_FRAC_BITS);
        rise_next = LVL_W'(rise_m >> HUE_FRAC_BITS);
        // exact x/255 for x up to 255*255
        fl_sum    = 17'(fl_reg) + 17'(fl_reg[15:8]) + 17'd1;
        ctx2_next = ctx1_reg;
        ctx2_next.floor_lvl = fl_sum[15:8];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            fall_reg <= fall_next;
            rise_reg <= rise_next;
            ctx2_reg <= ctx2_next;
        end
    end

    assign ctx_out  = ctx2_reg;
    assign fall_num = fall_reg;
    assign rise_num = rise_reg;

endmodule

// ===== design/hsv2rgb_div.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_div
// Exact divide by 255*60 through a reciprocal multiply, one register stage.
// ----------------------------------------------------------------------------
module hsv2rgb_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [hsv2rgb_pkg::LVL_W-1:0]    num,
    output logic [7:0]                       quot
);

    localparam int PW = hsv2rgb_pkg::LVL_W + hsv2rgb_pkg::RECIP_W;

    logic [PW-1:0] prod;
    logic [7:0]    quot_next;
    logic [7:0]    quot_reg;

    // reciprocal is rounded up and wide enough to be exact over the range
    always_comb
    begin
        prod      = PW'(num) * PW'(hsv2rgb_pkg::RECIP);
        quot_next = prod[hsv2rgb_pkg::DIV_SHIFT +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

// ===== design/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Six-sector hsv to rgb color converter with a valid/stall stream interface.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while hsv_stall is low and gives its rgb through
// a five-stage pipeline: sector decode, saturation products, level
// numerators, reciprocal divide, sector mux into the output register.
// Each stage advances when it is empty or the stage after it moves, so
// bubbles close up and a stalled output holds only the stages behind it.
// Hue is in 1/2^HUE_FRAC_BITS degree; a hue of a full turn or more is 0.
// Zero saturation gives grey at the brightness; all levels are truncated.
module hsv_to_rgb_converter_top #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hsv_valid,
    output logic                hsv_stall,
    input  hsv2rgb_pkg::hsv_t   hsv,
    output logic                rgb_valid,
    input  logic                rgb_stall,
    output hsv2rgb_pkg::rgb_t   rgb
);

    localparam int SECTOR_W = 60 << HUE_FRAC_BITS;
    localparam int POS_W    = $clog2(SECTOR_W);
    localparam int NUM_ST   = 5;

    logic [NUM_ST-1:0]                  valid_reg;
    logic [NUM_ST-1:0]                  valid_next;
    logic [NUM_ST:0]                    ready;

    hsv2rgb_pkg::ctx_t                  ctx_s0;
    logic [POS_W-1:0]                   pos_s0;
    logic [7:0]                         sat_s0;
    hsv2rgb_pkg::ctx_t                  ctx_s2;
    logic [hsv2rgb_pkg::LVL_W-1:0]      fall_num;
    logic [hsv2rgb_pkg::LVL_W-1:0]      rise_num;
    hsv2rgb_pkg::ctx_t                  ctx3_reg;
    logic [7:0]                         fall_lvl;
    logic [7:0]                         rise_lvl;
    hsv2rgb_pkg::rgb_t                  rgb_next;
    hsv2rgb_pkg::rgb_t                  rgb_reg;

    // pipeline flow control
    always_comb
    begin
        ready[NUM_ST] = !rgb_stall;
        for (int i = NUM_ST - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? hsv_valid : valid_reg[0];
        for (int i = 1; i < NUM_ST; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    hsv2rgb_sector #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SECTOR_W      (SECTOR_W),
        .POS_W         (POS_W)
    ) u_sector (
        .clk (clk),
        .en  (ready[0]),
        .pix (hsv),
        .ctx (ctx_s0),
        .pos (pos_s0),
        .sat (sat_s0)
    );

    hsv2rgb_levels #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SECTOR_W      (SECTOR_W),
        .POS_W         (POS_W)
    ) u_levels (
        .clk      (clk),
        .en       (ready[2:1]),
        .ctx_in   (ctx_s0),
        .pos      (pos_s0),
        .sat      (sat_s0),
        .ctx_out  (ctx_s2),
        .fall_num (fall_num),
        .rise_num (rise_num)
    );

    hsv2rgb_div u_div_fall (
        .clk  (clk),
        .en   (ready[3]),
        .num  (fall_num),
        .quot (fall_lvl)
    );

    hsv2rgb_div u_div_rise (
        .clk  (clk),
        .en   (ready[3]),
        .num  (rise_num),
        .quot (rise_lvl)
    );

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            ctx3_reg <= ctx_s2;
        end
    end

    // sector mux
    always_comb
    begin
        if (ctx3_reg.grey)
        begin
            rgb_next = '{red: ctx3_reg.val, green: ctx3_reg.val, blue: ctx3_reg.val};
        end
        else
        begin
            case (ctx3_reg.sector)
                hsv2rgb_pkg::SEC_RED_YEL:
                    rgb_next = '{red: ctx3_reg.val, green: rise_lvl,
                                 blue: ctx3_reg.floor_lvl};
                hsv2rgb_pkg::SEC_YEL_GRN:
                    rgb_next = '{red: fall_lvl, green: ctx3_reg.val,
                                 blue: ctx3_reg.floor_lvl};
                hsv2rgb_pkg::SEC_GRN_CYN:
                    rgb_next = '{red: ctx3_reg.floor_lvl, green: ctx3_reg.val,
                                 blue: rise_lvl};
                hsv2rgb_pkg::SEC_CYN_BLU:
                    rgb_next = '{red: ctx3_reg.floor_lvl, green: fall_lvl,
                                 blue: ctx3_reg.val};
                hsv2rgb_pkg::SEC_BLU_MAG:
                    rgb_next = '{red: rise_lvl, green: ctx3_reg.floor_lvl,
                                 blue: ctx3_reg.val};
                default:
                    rgb_next = '{red: ctx3_reg.val, green: ctx3_reg.floor_lvl,
                                 blue: fall_lvl};
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign hsv_stall = !ready[0];
    assign rgb_valid = valid_reg[NUM_ST-1];
    assign rgb       = rgb_reg;

endmodule

// ===== design/hsv2rgb_chk.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                hsv_valid,
    input logic                hsv_stall,
    input hsv2rgb_pkg::hsv_t   hsv,
    input logic                rgb_valid,
    input logic                rgb_stall,
    input hsv2rgb_pkg::rgb_t   rgb
);

    // a stalled result holds
    a_rgb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
        else $error("rgb changed while stalled");

    // with no result waiting the pipeline cannot be full
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !rgb_valid |-> !hsv_stall)
        else $error("input stalled with empty output");

    // a transfer in with free-running output comes out with rgb_valid set
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall) ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        ##1 !rgb_stall |=> rgb_valid)
        else $error("result missing after pipeline latency");

    // zero saturation gives grey at the brightness
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall && hsv.saturation == 8'd0) ##1 !rgb_stall
        ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
        |=> rgb.red == $past(hsv.brightness, 5) && rgb.green == $past(hsv.brightness, 5)
            && rgb.blue == $past(hsv.brightness, 5))
        else $error("grey pixel not passed through");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_chk u_hsv2rgb_chk (.*);

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams hsv pixels through the color converter and checks each rgb result
// against a six-sector fixed-point model held in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HUE_FRAC = 6;
    localparam longint unsigned SECTOR_SPAN = longint'(hsv2rgb_pkg::SECTOR_DEG) << HUE_FRAC;
    localparam longint unsigned TURN_SPAN   = longint'(hsv2rgb_pkg::TURN_DEG) << HUE_FRAC;
    localparam int RANDOM_PIXELS = 800;
    localparam int DRAIN_CYCLES  = 20;

    class color_scoreboard;
        hsv2rgb_pkg::hsv_t pending_hsv[$];
        hsv2rgb_pkg::rgb_t pending_rgb[$];
        int   mismatches = 0;

        function automatic hsv2rgb_pkg::rgb_t convert_pixel(hsv2rgb_pkg::hsv_t px);
            longint unsigned h, s, v, sector, pos, den, flr, fall, rise;
            hsv2rgb_pkg::rgb_t c;
            h = px.hue;
            s = px.saturation;
            v = px.brightness;
            if (s == 0) begin
                c.red   = v[7:0];
                c.green = v[7:0];
                c.blue  = v[7:0];
            end
            else begin
                if (h >= TURN_SPAN)
                    h = 0;
                sector = h / SECTOR_SPAN;
                pos    = h % SECTOR_SPAN;
                den    = longint'(hsv2rgb_pkg::FULL_SCALE) * SECTOR_SPAN;
                flr    = (v * (longint'(hsv2rgb_pkg::FULL_SCALE) - s))
                         / longint'(hsv2rgb_pkg::FULL_SCALE);
                fall   = (v * (den - s * pos)) / den;
                rise   = (v * (den - s * (SECTOR_SPAN - pos))) / den;
                case (sector[2:0])
                    hsv2rgb_pkg::SEC_RED_YEL: c = {v[7:0], rise[7:0], flr[7:0]};
                    hsv2rgb_pkg::SEC_YEL_GRN: c = {fall[7:0], v[7:0], flr[7:0]};
                    hsv2rgb_pkg::SEC_GRN_CYN: c = {flr[7:0], v[7:0], rise[7:0]};
                    hsv2rgb_pkg::SEC_CYN_BLU: c = {flr[7:0], fall[7:0], v[7:0]};
                    hsv2rgb_pkg::SEC_BLU_MAG: c = {rise[7:0], flr[7:0], v[7:0]};
                    default:                  c = {v[7:0], flr[7:0], fall[7:0]};
                endcase
            end
            return c;
        endfunction

        function void note_pixel(hsv2rgb_pkg::hsv_t px);
            pending_hsv.push_back(px);
            pending_rgb.push_back(convert_pixel(px));
        endfunction

        function int pending();
            return pending_rgb.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_rgb(hsv2rgb_pkg::rgb_t got);
            hsv2rgb_pkg::hsv_t src;
            hsv2rgb_pkg::rgb_t want;
            if (pending_rgb.size() == 0) begin
                report_mismatch($sformatf("rgb %h with no pixel pending", got));
                return;
            end
            src  = pending_hsv.pop_front();
            want = pending_rgb.pop_front();
            if (got.red !== want.red)
                report_mismatch($sformatf("hsv %h red %0d expected %0d",
                                          src, got.red, want.red));
            if (got.green !== want.green)
                report_mismatch($sformatf("hsv %h green %0d expected %0d",
                                          src, got.green, want.green));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("hsv %h blue %0d expected %0d",
                                          src, got.blue, want.blue));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic hsv_valid;
    logic hsv_stall;
    hsv2rgb_pkg::hsv_t hsv;
    logic rgb_valid;
    logic rgb_stall;
    hsv2rgb_pkg::rgb_t rgb;

    color_scoreboard colors = new();
    bit no_idle     = 1'b0;
    int hold_cycles = 0;

    hsv_to_rgb_converter_top #(
        .HUE_FRAC_BITS(HUE_FRAC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb       (rgb)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // both monitors see pre-edge values, so order within the step does not matter
    always @(posedge clk)
    begin
        if (rst_n && hsv_valid && !hsv_stall)
            colors.note_pixel(hsv);
    end

    always @(posedge clk)
    begin
        if (rst_n && rgb_valid && !rgb_stall)
            colors.check_rgb(rgb);
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // called just after a falling edge, returns just after a falling edge
    task automatic send_pixel(input hsv2rgb_pkg::hsv_t px);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            hsv_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        hsv       = px;
        hsv_valid = 1'b1;
        do
            @(posedge clk);
        while (hsv_stall);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        hsv_valid = 1'b0;
        while (colors.pending() != 0)
            @(negedge clk);
    endtask

    function automatic hsv2rgb_pkg::hsv_t random_pixel();
        hsv2rgb_pkg::hsv_t px;
        case ($urandom_range(0, 9))
            0: px.hue = 16'($urandom_range(int'(TURN_SPAN), 65535));
            1: px.hue = 16'(SECTOR_SPAN * $urandom_range(0, 5) + $urandom_range(0, 2) - 1);
            default: px.hue = 16'($urandom_range(0, int'(TURN_SPAN) - 1));
        endcase
        case ($urandom_range(0, 9))
            0: px.saturation = 8'd0;
            1: px.saturation = 8'd255;
            default: px.saturation = 8'($urandom_range(0, 255));
        endcase
        px.brightness = 8'($urandom_range(0, 255));
        return px;
    endfunction

    // receiver: random stall per transfer, plus one long hold on request
    initial
    begin
        rgb_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_cycles > 0) begin
                rgb_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else begin
                int gap;
                gap = draw_gap();
                if (gap > 0) begin
                    rgb_stall = 1'b1;
                    repeat (gap) @(negedge clk);
                end
            end
            rgb_stall = 1'b0;
            do
                @(posedge clk);
            while (!(rgb_valid && !rgb_stall));
            @(negedge clk);
        end
    end

    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        hsv_valid = 1'b0;
        hsv       = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sector edges, out-of-circle hues, grey and corner levels
        send_pixel({16'd0,     8'd255, 8'd255});
        send_pixel({16'd1,     8'd255, 8'd255});
        send_pixel({16'd3839,  8'd255, 8'd255});
        send_pixel({16'd3840,  8'd255, 8'd255});
        send_pixel({16'd7680,  8'd255, 8'd200});
        send_pixel({16'd11520, 8'd255, 8'd255});
        send_pixel({16'd15360, 8'd200, 8'd255});
        send_pixel({16'd19200, 8'd128, 8'd128});
        send_pixel({16'd23039, 8'd255, 8'd255});
        send_pixel({16'd23040, 8'd255, 8'd255});
        send_pixel({16'd23041, 8'd100, 8'd77});
        send_pixel({16'd65535, 8'd255, 8'd255});
        send_pixel({16'd65535, 8'd0,   8'd255});
        send_pixel({16'd12345, 8'd0,   8'd0});
        send_pixel({16'd12345, 8'd0,   8'd255});
        send_pixel({16'd12345, 8'd0,   8'd131});
        send_pixel({16'd1920,  8'd1,   8'd255});
        send_pixel({16'd1920,  8'd255, 8'd0});
        send_pixel({16'd5000,  8'd255, 8'd1});
        send_pixel({16'd9000,  8'd128, 8'd255});
        send_pixel({16'd17000, 8'd77,  8'd199});
        send_pixel({16'd21000, 8'd254, 8'd254});
        wait_results_drained();

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            // stretch with no idling on either side
            if (i == 100)
                no_idle = 1'b1;
            if (i == 200)
                no_idle = 1'b0;
            // long output hold while pixels keep coming, fills the pipeline
            if (i == 300) begin
                no_idle     = 1'b1;
                hold_cycles = 60;
            end
            if (i == 340)
                no_idle = 1'b0;
            // sender pauses until every result is back
            if (i == 450 || i == 650)
                wait_results_drained();
            send_pixel(random_pixel());
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (colors.mismatches == 0 && colors.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== hsv_to_rgb_converter_top.f =====
design/hsv2rgb_pkg.sv
design/hsv2rgb_sector.sv
design/hsv2rgb_levels.sv
design/hsv2rgb_div.sv
design/hsv_to_rgb_converter_top.sv
design/hsv2rgb_chk.sv
test/testbench.sv
